[sv/crtm_pkg.sv]
// ----------------------------------------------------------------------------
// crtm_pkg
// shared constants, codes and controller types of the rate timeout monitor
// ----------------------------------------------------------------------------
`default_nettype none
package crtm_pkg;
  localparam int CHANNELS         = 16;
  localparam int MAX_WINDOW       = 16;
  localparam int TICKS_PER_SECOND = 1000000;

  localparam int CH_W    = 4;
  localparam int WIN_W   = $clog2(MAX_WINDOW);
  localparam int CNT_W   = 5;
  localparam int TS_W    = 48;
  localparam int RATE_W  = 16;
  localparam int NUM_W   = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [NUM_W-1:0] RATE_SCALE = NUM_W'(TICKS_PER_SECOND * 256);

  localparam logic [CFG_IDX_W-1:0] REG_WARN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd3;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_EVAL    = 1'b1;

  localparam logic [1:0] LVL_OK    = 2'd0;
  localparam logic [1:0] LVL_WARN  = 2'd1;
  localparam logic [1:0] LVL_ERROR = 2'd2;

  localparam logic [2:0] RSN_OK        = 3'd0;
  localparam logic [2:0] RSN_NOT_RECV  = 3'd1;
  localparam logic [2:0] RSN_TIMEOUT   = 3'd2;
  localparam logic [2:0] RSN_ERR_RATE  = 3'd3;
  localparam logic [2:0] RSN_WARN_RATE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic arrive;
    logic capture;
    logic evaluate;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } status_t;
endpackage
`default_nettype wire

[sv/crtm_in_if.sv]
// ----------------------------------------------------------------------------
// crtm_in_if
// input channel: arrival or evaluation transaction
// ----------------------------------------------------------------------------
`default_nettype none
interface crtm_in_if;
  import crtm_pkg::*;
  logic            valid;
  logic            ready;
  logic            operation;
  logic [CH_W-1:0] channel;
  logic [TS_W-1:0] timestamp;
  modport source(output valid, operation, channel, timestamp, input ready);
  modport sink(input valid, operation, channel, timestamp, output ready);
endinterface
`default_nettype wire

[sv/crtm_out_if.sv]
// ----------------------------------------------------------------------------
// crtm_out_if
// result channel: one status report per evaluation
// ----------------------------------------------------------------------------
`default_nettype none
interface crtm_out_if;
  import crtm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel_out;
  logic [1:0]        level;
  logic [2:0]        reason;
  logic              rate_valid;
  logic [RATE_W-1:0] rate_q88;
  modport source(output valid, channel_out, level, reason, rate_valid, rate_q88,
                 input ready);
  modport sink(input valid, channel_out, level, reason, rate_valid, rate_q88,
               output ready);
endinterface
`default_nettype wire

[sv/crtm_ram.sv]
// ----------------------------------------------------------------------------
// crtm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module crtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/crtm_ctrl.sv]
// ----------------------------------------------------------------------------
// crtm_ctrl
// sequencer: accepts transactions, steps the divider, hands off the result
// ----------------------------------------------------------------------------
`default_nettype none
module crtm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_op,
  output logic                   in_ready,
  input  wire crtm_pkg::status_t status,
  output crtm_pkg::cmd_t         cmd
);
  import crtm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_ARRIVAL) begin
            cmd.arrive = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.evaluate = 1'b1;
        state_nxt    = status.need_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[sv/crtm_dp.sv]
// ----------------------------------------------------------------------------
// crtm_dp
// datapath: channel state, arrival window ram, restoring divider, result reg
// ----------------------------------------------------------------------------
`default_nettype none
module crtm_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire crtm_pkg::cmd_t                  cmd,
  output crtm_pkg::status_t                    status,
  input  wire logic                            cfg_we,
  input  wire logic [crtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crtm_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic [crtm_pkg::CH_W-1:0]       in_channel,
  input  wire logic [crtm_pkg::TS_W-1:0]       in_timestamp,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [crtm_pkg::CH_W-1:0]            out_channel,
  output logic [1:0]                           out_level,
  output logic [2:0]                           out_reason,
  output logic                                 out_rate_valid,
  output logic [crtm_pkg::RATE_W-1:0]          out_rate
);
  import crtm_pkg::*;

  logic [RATE_W-1:0] warn_r, error_r;
  logic [31:0]       timeout_r;
  logic [CNT_W-1:0]  wlen_r;

  logic [TS_W-1:0]   last_r  [CHANNELS];
  logic              recv_r  [CHANNELS];
  logic [WIN_W-1:0]  head_r  [CHANNELS];
  logic [CNT_W-1:0]  count_r [CHANNELS];

  logic [CH_W-1:0]   ch_r;
  logic [TS_W-1:0]   ts_r;
  logic [1:0]        lvl_r;
  logic [2:0]        rsn_r;
  logic              rv_r;
  logic [TS_W-1:0]   span_r;
  logic [NUM_W-1:0]  num_r, q_r;
  logic [TS_W-1:0]   rem_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic              out_valid_r;

  logic [TS_W-1:0]   front;
  logic [CNT_W-1:0]  eff_len, cnt_a, cnt_inc;
  logic [WIN_W-1:0]  head_a, slot;
  logic [CH_W+WIN_W-1:0] raddr;
  logic [TS_W-1:0]   last_e;
  logic [CNT_W-1:0]  cnt_e;
  logic              tout, need_div;
  logic [TS_W:0]     rem_sh;
  logic              ge;
  logic [RATE_W-1:0] rate_sat;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_r    <= 16'd128;
      error_r   <= 16'd26;
      timeout_r <= 32'd1000000;
      wlen_r    <= 5'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WARN:    warn_r    <= cfg_data[RATE_W-1:0];
        REG_ERROR:   error_r   <= cfg_data[RATE_W-1:0];
        REG_TIMEOUT: timeout_r <= cfg_data;
        REG_WINDOW:  wlen_r    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // arrival bookkeeping
  assign eff_len = (wlen_r > CNT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : wlen_r;
  assign head_a  = head_r[in_channel];
  assign cnt_a   = count_r[in_channel];
  assign cnt_inc = cnt_a + 1'b1;
  assign slot    = head_a + cnt_a[WIN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        recv_r[i]  <= 1'b0;
        head_r[i]  <= '0;
        count_r[i] <= '0;
        last_r[i]  <= '0;
      end
    end else if (cmd.arrive) begin
      last_r[in_channel] <= in_timestamp;
      recv_r[in_channel] <= 1'b1;
      if (cnt_inc > eff_len) begin
        head_r[in_channel]  <= head_a + WIN_W'(cnt_inc - eff_len);
        count_r[in_channel] <= eff_len;
      end else begin
        count_r[in_channel] <= cnt_inc;
      end
    end
  end

  assign raddr = {in_channel, head_a};

  crtm_ram #(
    .WIDTH(TS_W),
    .DEPTH(CHANNELS * MAX_WINDOW)
  ) u_win_ram (
    .clk  (clk),
    .we   (cmd.arrive),
    .waddr({in_channel, slot}),
    .wdata(in_timestamp),
    .raddr(raddr),
    .rdata(front)
  );

  // evaluation
  assign last_e = last_r[ch_r];
  assign cnt_e  = count_r[ch_r];
  assign tout   = (timeout_r != '0) && (ts_r > last_e) &&
                  ((ts_r - last_e) > TS_W'(timeout_r));
  assign need_div = recv_r[ch_r] && !tout && (cnt_e >= CNT_W'(2)) && (ts_r > front);
  assign status.need_div = need_div;
  assign status.div_last = (dcnt_r == DIV_CNT_W'(NUM_W - 1));
  assign status.out_free = !out_valid_r || out_ready;

  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_r <= in_channel;
      ts_r <= in_timestamp;
    end
    if (cmd.evaluate) begin
      rv_r   <= need_div;
      span_r <= ts_r - front;
      num_r  <= NUM_W'(cnt_e - 1'b1) * RATE_SCALE;
      rem_r  <= '0;
      q_r    <= '0;
      dcnt_r <= '0;
      if (!recv_r[ch_r]) begin
        lvl_r <= LVL_ERROR;
        rsn_r <= RSN_NOT_RECV;
      end else if (tout) begin
        lvl_r <= LVL_ERROR;
        rsn_r <= RSN_TIMEOUT;
      end else begin
        lvl_r <= LVL_OK;
        rsn_r <= RSN_OK;
      end
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? TS_W'(rem_sh - {1'b0, span_r}) : rem_sh[TS_W-1:0];
      q_r    <= {q_r[NUM_W-2:0], ge};
      num_r  <= {num_r[NUM_W-2:0], 1'b0};
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // result register
  assign rate_sat = !rv_r ? '0 :
                    (q_r > NUM_W'({RATE_W{1'b1}})) ? {RATE_W{1'b1}} : q_r[RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel    <= ch_r;
      out_rate_valid <= rv_r;
      out_rate       <= rate_sat;
      if (rv_r && error_r != '0 && rate_sat < error_r) begin
        out_level  <= LVL_ERROR;
        out_reason <= RSN_ERR_RATE;
      end else if (rv_r && warn_r != '0 && rate_sat < warn_r) begin
        out_level  <= LVL_WARN;
        out_reason <= RSN_WARN_RATE;
      end else begin
        out_level  <= lvl_r;
        out_reason <= rsn_r;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transaction");
  a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rate_valid) |-> (out_rate == '0))
    else $error("rate reported without measurement");
  a_ok_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_level == LVL_OK) |-> (out_reason == RSN_OK))
    else $error("ok level with a fault reason");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.evaluate && need_div) |=> (dcnt_r == '0))
    else $error("divider not restarted");
endmodule
`default_nettype wire

[sv/channel_rate_timeout_monitor.sv]
// ----------------------------------------------------------------------------
// channel_rate_timeout_monitor
// per-channel arrival monitor with timeout and window rate checks
// ----------------------------------------------------------------------------
// usage
//   in_ch carries transactions: operation 0 records an arrival time for a
//   channel, operation 1 asks for that channel's status
//   out_ch carries one status report per evaluation, none per arrival
//   cfg_we/cfg_index/cfg_data write the rate limits, timeout and window length
// timing
//   an arrival is recorded when taken, the next transaction the cycle after
//   an evaluation steps through read, divide (only with a rate measurement)
//   and done; the 32-step restoring divider yields one quotient bit a cycle
//   the report goes to an output register, so the next transaction is taken
//   while the report waits
// reset
//   received flags, window counts and heads and last-seen times clear at once;
//   config registers return to their defaults; the window ram is not cleared
// stall
//   a stalled receiver holds the report; a second finished evaluation waits
//   in the controller and no further transaction is taken until it moves
// ----------------------------------------------------------------------------
`default_nettype none
module channel_rate_timeout_monitor (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  crtm_in_if.sink                             in_ch,
  crtm_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [crtm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crtm_pkg::CFG_W-1:0]     cfg_data
);
  import crtm_pkg::*;

  cmd_t    cmd;
  status_t status;

  crtm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_op   (in_ch.operation),
    .in_ready(in_ch.ready),
    .status  (status),
    .cmd     (cmd)
  );

  crtm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_channel    (in_ch.channel),
    .in_timestamp  (in_ch.timestamp),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_channel   (out_ch.channel_out),
    .out_level     (out_ch.level),
    .out_reason    (out_ch.reason),
    .out_rate_valid(out_ch.rate_valid),
    .out_rate      (out_ch.rate_q88)
  );
endmodule
`default_nettype wire
